// ===== rtl/dsmc_pkg.sv =====
// Shared types, constants and helpers for the disjoint set maximum cover unit.
package dsmc_pkg;

    localparam int VIEWS     = 16;
    localparam int MEMBERS   = 64;
    localparam int SET_W     = 64;
    localparam int COV_W     = 7;
    localparam int IDX_W     = $clog2(VIEWS);
    localparam int CNT_W     = $clog2(VIEWS + 1);
    localparam logic [SET_W-1:0] MEMBER_MASK = {SET_W{1'b1}} >> (SET_W - MEMBERS);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [SET_W-1:0] set_bits;
        logic             last_set;
    } item_t;

    typedef struct packed {
        logic [VIEWS-1:0] best_subset;
        logic [COV_W-1:0] covered_members;
        logic [1:0]       status;
    } result_t;

    // Datapath operations selected by the current control word.
    typedef struct packed {
        logic init_search;
        logic init_mask;
        logic mem_read;
        logic accumulate;
        logic judge;
        logic emit_search;
        logic emit_ovf;
    } seq_ctrl_t;

    // Conditions the sequencer may branch on.
    typedef struct packed {
        logic go;
        logic ovf;
        logic few;
        logic k_last;
        logic p_full;
    } seq_flags_t;

    // Balanced adder tree: six levels of narrow adds.
    function automatic logic [COV_W-1:0] pop64(input logic [SET_W-1:0] x);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++)
            l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        for (int i = 0; i < 16; i++)
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 8; i++)
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 4; i++)
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        for (int i = 0; i < 2; i++)
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

endpackage

// ===== rtl/dsmc_seq.sv =====
// Microcoded sequencer: step counter, control store and branch selection.
module dsmc_seq
    import dsmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output seq_ctrl_t  ctrl,
    output logic       busy
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHK_OVF  = 4'd1;
    localparam logic [3:0] S_CHK_FEW  = 4'd2;
    localparam logic [3:0] S_MASK     = 4'd3;
    localparam logic [3:0] S_READ     = 4'd4;
    localparam logic [3:0] S_ACC      = 4'd5;
    localparam logic [3:0] S_JUDGE    = 4'd6;
    localparam logic [3:0] S_FINISH   = 4'd7;
    localparam logic [3:0] S_EMIT_OVF = 4'd8;

    localparam logic [2:0] C_ALWAYS = 3'd0;
    localparam logic [2:0] C_GO     = 3'd1;
    localparam logic [2:0] C_OVF    = 3'd2;
    localparam logic [2:0] C_FEW    = 3'd3;
    localparam logic [2:0] C_K_LAST = 3'd4;
    localparam logic [2:0] C_P_FULL = 3'd5;

    typedef struct packed {
        seq_ctrl_t  ctrl;
        logic [2:0] cond;
        logic [3:0] on_true;
        logic [3:0] on_false;
    } uword_t;

    function automatic uword_t rom(input logic [3:0] addr);
        uword_t w;
        w = '0;
        case (addr)
            S_IDLE:
            begin
                w.cond = C_GO;       w.on_true = S_CHK_OVF; w.on_false = S_IDLE;
            end
            S_CHK_OVF:
            begin
                w.cond = C_OVF;      w.on_true = S_EMIT_OVF; w.on_false = S_CHK_FEW;
            end
            S_CHK_FEW:
            begin
                w.ctrl.init_search = 1'b1;
                w.cond = C_FEW;      w.on_true = S_FINISH; w.on_false = S_MASK;
            end
            S_MASK:
            begin
                w.ctrl.init_mask = 1'b1;
                w.cond = C_ALWAYS;   w.on_true = S_READ;   w.on_false = S_READ;
            end
            S_READ:
            begin
                w.ctrl.mem_read = 1'b1;
                w.cond = C_ALWAYS;   w.on_true = S_ACC;    w.on_false = S_ACC;
            end
            S_ACC:
            begin
                w.ctrl.accumulate = 1'b1;
                w.cond = C_K_LAST;   w.on_true = S_JUDGE;  w.on_false = S_READ;
            end
            S_JUDGE:
            begin
                w.ctrl.judge = 1'b1;
                w.cond = C_P_FULL;   w.on_true = S_FINISH; w.on_false = S_MASK;
            end
            S_FINISH:
            begin
                w.ctrl.emit_search = 1'b1;
                w.cond = C_ALWAYS;   w.on_true = S_IDLE;   w.on_false = S_IDLE;
            end
            S_EMIT_OVF:
            begin
                w.ctrl.emit_ovf = 1'b1;
                w.cond = C_ALWAYS;   w.on_true = S_IDLE;   w.on_false = S_IDLE;
            end
            default:
            begin
                w.cond = C_ALWAYS;   w.on_true = S_IDLE;   w.on_false = S_IDLE;
            end
        endcase
        return w;
    endfunction

    logic [3:0] step_reg;
    logic [3:0] step_next;
    uword_t     word;
    logic       taken;

    always_comb
    begin
        word = rom(step_reg);
        case (word.cond)
            C_ALWAYS: taken = 1'b1;
            C_GO:     taken = flags.go;
            C_OVF:    taken = flags.ovf;
            C_FEW:    taken = flags.few;
            C_K_LAST: taken = flags.k_last;
            C_P_FULL: taken = flags.p_full;
            default:  taken = 1'b1;
        endcase
        step_next = taken ? word.on_true : word.on_false;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_IDLE;
        else
            step_reg <= step_next;
    end

    assign ctrl = word.ctrl;
    assign busy = (step_reg != S_IDLE);

endmodule

// ===== rtl/disjoint_set_max_cover_unit.sv =====
// Top level: set store, search datapath and result register.
// Load: one set per cycle while busy is low; a set past VIEWS is dropped and flagged.
// Search after the last set with n sets stored: every one of the 2^n - 1 subset masks
// gets a mask init, one store read and one add per set, and a judge step; done then rises.
// Too many sets: overflow result with no search; fewer than two sets: no mask is tried.
// Reset clears the counters and the sequencer; the set store holds no reset value.
module disjoint_set_max_cover_unit
    import dsmc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    typedef struct packed {
        logic [COV_W-1:0] pop;
        logic [SET_W-1:0] bits;
    } entry_t;

    entry_t store [VIEWS];
    entry_t rd_q;

    seq_ctrl_t  ctrl;
    seq_flags_t flags;
    logic       accept;

    logic [CNT_W-1:0] count_reg,    count_next;
    logic             ovf_reg,      ovf_next;
    logic [VIEWS-1:0] p_reg,        p_next;
    logic [IDX_W-1:0] k_reg,        k_next;
    logic [SET_W-1:0] uni_reg,      uni_next;
    logic             disj_reg,     disj_next;
    logic [1:0]       nsel_reg,     nsel_next;
    logic [COV_W-1:0] cov_reg,      cov_next;
    logic             have_reg,     have_next;
    logic [VIEWS-1:0] best_reg,     best_next;
    logic [COV_W-1:0] best_cov_reg, best_cov_next;
    result_t          result_reg,   result_next;
    logic             done_reg,     done_next;

    logic [SET_W-1:0] load_bits;
    logic [VIEWS-1:0] full_mask;
    logic [CNT_W-1:0] shift_amt;
    logic             better;

    dsmc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    assign accept    = start && !busy;
    assign load_bits = item.set_bits & MEMBER_MASK;
    assign shift_amt = CNT_W'(VIEWS) - count_reg;
    assign full_mask = {VIEWS{1'b1}} >> shift_amt;

    assign flags.go     = accept && item.last_set;
    assign flags.ovf    = ovf_reg;
    assign flags.few    = (count_reg < CNT_W'(2));
    assign flags.k_last = (k_reg == IDX_W'(count_reg - CNT_W'(1)));
    assign flags.p_full = (p_reg == full_mask);

    assign better = disj_reg && nsel_reg[1] && (!have_reg || cov_reg > best_cov_reg);

    // Set store: one write port for the load, one registered read port for the search.
    always_ff @(posedge clk)
    begin
        if (accept && count_reg < CNT_W'(VIEWS))
            store[count_reg[IDX_W-1:0]] <= '{pop: pop64(load_bits), bits: load_bits};
        if (ctrl.mem_read)
            rd_q <= store[k_reg];
    end

    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        uni_next      = uni_reg;
        disj_next     = disj_reg;
        nsel_next     = nsel_reg;
        cov_next      = cov_reg;
        have_next     = have_reg;
        best_next     = best_reg;
        best_cov_next = best_cov_reg;
        result_next   = result_reg;
        done_next     = 1'b0;

        if (accept)
        begin
            if (count_reg < CNT_W'(VIEWS))
                count_next = count_reg + CNT_W'(1);
            else
                ovf_next = 1'b1;
        end

        if (ctrl.init_search)
        begin
            have_next = 1'b0;
            p_next    = VIEWS'(1);
        end

        if (ctrl.init_mask)
        begin
            k_next    = '0;
            uni_next  = '0;
            disj_next = 1'b1;
            nsel_next = '0;
            cov_next  = '0;
        end

        // Fold one stored set into the running union when its bit is in the mask.
        if (ctrl.accumulate)
        begin
            if (p_reg[k_reg])
            begin
                if ((uni_reg & rd_q.bits) != '0)
                    disj_next = 1'b0;
                uni_next = uni_reg | rd_q.bits;
                cov_next = cov_reg + rd_q.pop;
                if (!nsel_reg[1])
                    nsel_next = nsel_reg + 2'd1;
            end
            k_next = k_reg + IDX_W'(1);
        end

        if (ctrl.judge)
        begin
            if (better)
            begin
                have_next     = 1'b1;
                best_next     = p_reg;
                best_cov_next = cov_reg;
            end
            p_next = p_reg + VIEWS'(1);
        end

        if (ctrl.emit_search)
        begin
            done_next = 1'b1;
            if (have_reg)
                result_next = '{best_subset: best_reg, covered_members: best_cov_reg,
                                status: ST_OK};
            else
                result_next = '{best_subset: '0, covered_members: '0, status: ST_NONE};
            count_next = '0;
            ovf_next   = 1'b0;
        end

        if (ctrl.emit_ovf)
        begin
            done_next   = 1'b1;
            result_next = '{best_subset: '0, covered_members: '0, status: ST_OVF};
            count_next  = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            p_reg        <= '0;
            k_reg        <= '0;
            uni_reg      <= '0;
            disj_reg     <= 1'b0;
            nsel_reg     <= '0;
            cov_reg      <= '0;
            have_reg     <= 1'b0;
            best_reg     <= '0;
            best_cov_reg <= '0;
            result_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            p_reg        <= p_next;
            k_reg        <= k_next;
            uni_reg      <= uni_next;
            disj_reg     <= disj_next;
            nsel_reg     <= nsel_next;
            cov_reg      <= cov_next;
            have_reg     <= have_next;
            best_reg     <= best_next;
            best_cov_reg <= best_cov_next;
            result_reg   <= result_next;
            done_reg     <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A result only follows a search or check that held the sequencer busy.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding busy cycle");

    // A winning group always holds at least two sets.
    a_ok_two_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_OK) |-> ($countones(result.best_subset) >= 2))
        else $error("ok result with fewer than two sets");

    // Failure results carry an empty group and no coverage.
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |->
            (result.best_subset == '0 && result.covered_members == '0))
        else $error("failure result with nonzero payload");

    // The load counter is back to zero right after any result.
    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (count_reg == '0 || $past(accept)))
        else $error("set count not cleared after result");

endmodule

// ===== tb/disjoint_set_max_cover_unit_tb.sv =====
// Testbench for the disjoint set maximum cover unit: directed and random set loads.
module disjoint_set_max_cover_unit_tb;
    import dsmc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic    clk;
    logic    rst_n;
    logic    start;
    item_t   item_bus;
    logic    busy;
    logic    done;
    result_t result;

    // Shadow of the block's load state
    logic [SET_W-1:0] held_sets [VIEWS];
    int unsigned      held_count;
    bit               held_overflow;

    result_t pending_results[$];
    int      error_count;
    int      sender_idle_pct;
    int      sets_sent;

    disjoint_set_max_cover_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item_bus),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("disjoint_set_max_cover_unit_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Exhaustive search over held sets, lowest subset mask first.
    function automatic result_t best_disjoint_cover(input int unsigned n);
        result_t          res;
        logic [SET_W-1:0] union_bits;
        bit               clash;
        bit               found;
        int unsigned      best_cov;
        int unsigned      cov;
        res = '0;
        found = 1'b0;
        best_cov = 0;
        if (n >= 2)
        begin
            for (int unsigned p = 1; p < (32'd1 << n); p++)
            begin
                if ($countones(p) < 2)
                    continue;
                union_bits = '0;
                clash = 1'b0;
                for (int k = 0; k < n; k++)
                begin
                    if (p[k])
                    begin
                        if ((union_bits & held_sets[k]) != '0)
                            clash = 1'b1;
                        union_bits |= held_sets[k];
                    end
                end
                if (clash)
                    continue;
                cov = $countones(union_bits);
                if (!found || cov > best_cov)
                begin
                    found = 1'b1;
                    best_cov = cov;
                    res.best_subset = p[VIEWS-1:0];
                    res.covered_members = best_cov[COV_W-1:0];
                end
            end
        end
        res.status = found ? ST_OK : ST_NONE;
        return res;
    endfunction

    task automatic load_set(input logic [SET_W-1:0] bits, input logic last);
        result_t res;
        if (held_count < VIEWS)
        begin
            held_sets[held_count] = bits & MEMBER_MASK;
            held_count++;
        end
        else
            held_overflow = 1'b1;
        if (last)
        begin
            if (held_overflow)
            begin
                res = '0;
                res.status = ST_OVF;
            end
            else
                res = best_disjoint_cover(held_count);
            pending_results = {pending_results, res};
            held_count = 0;
            held_overflow = 1'b0;
        end
    endtask

    // Drive one set and hold it until the block takes the transfer.
    task automatic send_set(input logic [SET_W-1:0] bits, input logic last);
        item_t it;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        it.set_bits = bits;
        it.last_set = last;
        start    <= 1'b1;
        item_bus <= it;
        do
            @(posedge clk);
        while (busy);
        load_set(bits, last);
        sets_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SET_W-1:0] random_set();
        logic [SET_W-1:0] bits;
        int               kind;
        kind = $urandom_range(9);
        bits = '0;
        case (kind)
            0: bits = '0;
            1: bits = '1;
            2, 3: bits = {$urandom, $urandom};
            default:
            begin
                repeat ($urandom_range(5))
                    bits[$urandom_range(SET_W-1)] = 1'b1;
            end
        endcase
        return bits;
    endfunction

    task automatic load_random_group(input int n);
        for (int i = 0; i < n; i++)
            send_set(random_set(), i == n - 1);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (result.best_subset !== want.best_subset)
                    report_mismatch($sformatf("best_subset: expected %h, got %h",
                        want.best_subset, result.best_subset));
                if (result.covered_members !== want.covered_members)
                    report_mismatch($sformatf("covered_members: expected %0d, got %0d",
                        want.covered_members, result.covered_members));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status: expected %0d, got %0d",
                        want.status, result.status));
            end
        end
    end

    task automatic test_single_set();
        send_set('1, 1'b1);
        wait_drained();
    endtask

    // Two halves cover every member.
    task automatic test_disjoint_halves();
        send_set(64'hFFFF_FFFF_0000_0000, 1'b0);
        send_set(64'h0000_0000_FFFF_FFFF, 1'b1);
        send_set('1, 1'b0);
        send_set('1, 1'b1);
        wait_drained();
    endtask

    task automatic test_zero_cover();
        send_set('0, 1'b0);
        send_set('0, 1'b1);
        wait_drained();
    endtask

    // Equal coverage later in mask order must not replace the first winner.
    task automatic test_tie_keeps_first();
        send_set(64'h1, 1'b0);
        send_set(64'h2, 1'b0);
        send_set(64'h2, 1'b1);
        send_set(64'h8000_0000_0000_0000, 1'b0);
        send_set(64'h6, 1'b0);
        send_set(64'h3, 1'b1);
        wait_drained();
    endtask

    task automatic test_overflow();
        for (int i = 0; i <= VIEWS; i++)
            send_set(random_set(), i == VIEWS);
        wait_drained();
    endtask

    task automatic test_large_load();
        load_random_group(12);
        wait_drained();
    endtask

    task automatic test_random_loads(input int idle_pct, input int target);
        int stop_at;
        int pick;
        sender_idle_pct = idle_pct;
        stop_at = sets_sent + target;
        while (sets_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                load_random_group($urandom_range(VIEWS + 1, VIEWS + 4));
            else if (pick < 10)
                load_random_group($urandom_range(7, 9));
            else
                load_random_group($urandom_range(1, 6));
            if ($urandom_range(99) < 6)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item_bus = '0;
        held_count = 0;
        held_overflow = 1'b0;
        error_count = 0;
        sets_sent = 0;
        sender_idle_pct = 19;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_set();
        test_disjoint_halves();
        test_zero_cover();
        test_tie_keeps_first();
        test_overflow();
        test_large_load();
        test_random_loads(19, 200);
        test_random_loads(65, 200);
        test_random_loads(0, 200);

        start <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("expected results never arrived");
        if (error_count == 0)
            $display("disjoint_set_max_cover_unit_tb: clean");
        else
            $display("disjoint_set_max_cover_unit_tb: errors");
        $finish;
    end

endmodule
